// File: sv/eqpq_pkg.sv
package eqpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 16;
    localparam int PORT_TIME_W     = 16;
    localparam int TOTAL_W         = 16;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

endpackage

// File: sv/eqpq_ram.sv
module eqpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/expiry_sorted_priority_queue_top.sv
// expiry-sorted priority queue
// command channel: start with i_operation, i_expiry_time, i_unit_class is taken
// at a rising edge where start is high and busy is low. operations are query,
// insert, remove head and clear the insertion counter.
// result channel: o_valid is high for one cycle and marks the transaction on
// o_head_time, o_queue_empty, o_occupancy, o_class_a_held, o_class_b_held,
// o_inserted_total and o_insert_dropped, all describing the queue after the
// operation. the receiver cannot hold a result off.
// entries sit in a circular buffer in one RAM (one write, one registered read
// port). remove advances the head pointer. insert walks from the tail toward
// the head, one RAM read and compare per entry, moving larger entries up one.
// sequence: query, remove, clear and a refused insert pass S_HEAD and S_HWAIT
// before o_valid; an insert first passes S_SCAN and S_WAIT for each compared
// held entry (up to occupancy), with a final S_SCAN when the entry lands at the
// head. busy drops in the strobe cycle, so the next command may be accepted
// there.
// reset empties the queue and zeroes the class counts and insertion counter;
// RAM contents are left as they are.
module expiry_sorted_priority_queue_top
    import eqpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_operation,
    input  logic [PORT_TIME_W-1:0] i_expiry_time,
    input  logic                   i_unit_class,
    output logic                   o_valid,
    output logic [PORT_TIME_W-1:0] o_head_time,
    output logic                   o_queue_empty,
    output logic [CNT_W-1:0]       o_occupancy,
    output logic [CNT_W-1:0]       o_class_a_held,
    output logic [CNT_W-1:0]       o_class_b_held,
    output logic [TOTAL_W-1:0]     o_inserted_total,
    output logic                   o_insert_dropped
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int ENT_W  = TIME_BITS + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WAIT  = 5'b00100,
        S_HEAD  = 5'b01000,
        S_HWAIT = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]     r_cnt_b, n_cnt_b;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic                 r_dropped, n_dropped;
    logic                 r_valid, n_valid;
    logic [TIME_BITS-1:0] r_key, n_key;
    logic                 r_cls, n_cls;
    logic [ADDR_W-1:0]    r_idx, n_idx;
    logic                 r_head_cls, n_head_cls;
    logic [PORT_TIME_W-1:0] r_head_time, n_head_time;

    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [ENT_W-1:0]     w_wdata;
    logic [ADDR_W-1:0]    w_raddr;
    logic [ENT_W-1:0]     w_rdata;
    logic [TIME_BITS-1:0] w_rd_time;
    logic                 w_rd_cls;
    t_op                  w_op;

    function automatic logic [ADDR_W-1:0] f_phys(input logic [ADDR_W-1:0] head,
                                                 input logic [ADDR_W-1:0] pos);
        logic [ADDR_W:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
            s = s - (ADDR_W+1)'(QUEUE_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    eqpq_ram #(
        .WIDTH(ENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd_time = w_rdata[TIME_BITS-1:0];
    assign w_rd_cls  = w_rdata[TIME_BITS];
    assign w_op      = t_op'(i_operation);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_total     = r_total;
        n_dropped   = r_dropped;
        n_valid     = 1'b0;
        n_key       = r_key;
        n_cls       = r_cls;
        n_idx       = r_idx;
        n_head_cls  = r_head_cls;
        n_head_time = r_head_time;
        w_we        = 1'b0;
        w_waddr     = f_phys(r_head, r_idx);
        w_wdata     = {r_cls, r_key};
        w_raddr     = r_head;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key     = TIME_BITS'(i_expiry_time);
                    n_cls     = i_unit_class;
                    n_dropped = 1'b0;
                    n_state   = S_HEAD;
                    case (w_op)
                        OP_INSERT: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_idx   = r_count[ADDR_W-1:0];
                                n_count = r_count + 1'b1;
                                if (i_unit_class) begin
                                    n_cnt_b = r_cnt_b + 1'b1;
                                end else begin
                                    n_cnt_a = r_cnt_a + 1'b1;
                                end
                                if (r_total != '1) begin
                                    n_total = r_total + 1'b1;
                                end
                                n_state = S_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count != '0) begin
                                n_head  = f_phys(r_head, ADDR_W'(1));
                                n_count = r_count - 1'b1;
                                if (r_head_cls) begin
                                    n_cnt_b = r_cnt_b - 1'b1;
                                end else begin
                                    n_cnt_a = r_cnt_a - 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_total = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_state = S_HEAD;
                end else begin
                    w_raddr = f_phys(r_head, r_idx - 1'b1);
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                w_we = 1'b1;
                if (w_rd_time > r_key) begin
                    w_wdata = w_rdata;
                    n_idx   = r_idx - 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_HWAIT;
            end
            S_HWAIT: begin
                n_valid     = 1'b1;
                n_head_cls  = w_rd_cls;
                n_head_time = (r_count == '0) ? '0 : PORT_TIME_W'(w_rd_time);
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_total   <= '0;
            r_dropped <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_cnt_a   <= n_cnt_a;
            r_cnt_b   <= n_cnt_b;
            r_total   <= n_total;
            r_dropped <= n_dropped;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_cls       <= n_cls;
        r_idx       <= n_idx;
        r_head_cls  <= n_head_cls;
        r_head_time <= n_head_time;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_head_time      = r_head_time;
    assign o_queue_empty    = (r_count == '0);
    assign o_occupancy      = r_count;
    assign o_class_a_held   = r_cnt_a;
    assign o_class_b_held   = r_cnt_b;
    assign o_inserted_total = r_total;
    assign o_insert_dropped = r_dropped;

endmodule

// File: sv/eqpq_checker.sv
module eqpq_checker
    import eqpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_valid,
    input logic [PORT_TIME_W-1:0] o_head_time,
    input logic                   o_queue_empty,
    input logic [CNT_W-1:0]       o_occupancy,
    input logic [CNT_W-1:0]       o_class_a_held,
    input logic [CNT_W-1:0]       o_class_b_held,
    input logic                   o_insert_dropped
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_queue_empty == (o_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_queue_empty) |-> (o_head_time == '0))
        else $error("head time not zero on empty queue");

    a_class_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((CNT_W+1)'(o_class_a_held) + (CNT_W+1)'(o_class_b_held)
                     == (CNT_W+1)'(o_occupancy)))
        else $error("class counts do not add up to occupancy");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_insert_dropped) |-> (o_occupancy == CNT_W'(QUEUE_DEPTH)))
        else $error("insert dropped while queue not full");

endmodule

bind expiry_sorted_priority_queue_top eqpq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_eqpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_head_time     (o_head_time),
    .o_queue_empty   (o_queue_empty),
    .o_occupancy     (o_occupancy),
    .o_class_a_held  (o_class_a_held),
    .o_class_b_held  (o_class_b_held),
    .o_insert_dropped(o_insert_dropped)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import eqpq_pkg::*;

    localparam int SLOTS       = 16;
    localparam int RAND_ITEMS  = 1650;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 60;
    localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] head;
        logic        empty;
        logic [4:0]  occ;
        logic [4:0]  held_a;
        logic [4:0]  held_b;
        logic [15:0] total;
        logic        dropped;
    } t_queue_status;

    typedef struct {
        t_op           op;
        logic [15:0]   tm;
        logic          cls;
        bit            fixed;
        t_queue_status lit;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_operation = OP_QUERY;
    logic [15:0] i_expiry_time = '0;
    logic        i_unit_class = 1'b0;
    logic        busy;
    logic        o_valid;
    logic [15:0] o_head_time;
    logic        o_queue_empty;
    logic [4:0]  o_occupancy;
    logic [4:0]  o_class_a_held;
    logic [4:0]  o_class_b_held;
    logic [15:0] o_inserted_total;
    logic        o_insert_dropped;

    // predictor state
    logic [15:0] slot_tm [SLOTS];
    logic        slot_cls [SLOTS];
    int          held_cnt = 0;
    int          cnt_a = 0;
    int          cnt_b = 0;
    logic [15:0] ins_total = '0;

    t_queue_status status_fifo [$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    t_dir_row      directed_rows [25];

    expiry_sorted_priority_queue_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_expiry_time   (i_expiry_time),
        .i_unit_class    (i_unit_class),
        .o_valid         (o_valid),
        .o_head_time     (o_head_time),
        .o_queue_empty   (o_queue_empty),
        .o_occupancy     (o_occupancy),
        .o_class_a_held  (o_class_a_held),
        .o_class_b_held  (o_class_b_held),
        .o_inserted_total(o_inserted_total),
        .o_insert_dropped(o_insert_dropped)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_queue_status apply_queue_op(t_op op, logic [15:0] tm, logic cls);
        t_queue_status s;
        int pos;
        s.dropped = 1'b0;
        case (op)
            OP_INSERT: begin
                if (held_cnt == SLOTS) begin
                    s.dropped = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < held_cnt && slot_tm[pos] <= tm) pos++;
                    for (int i = held_cnt; i > pos; i--) begin
                        slot_tm[i]  = slot_tm[i-1];
                        slot_cls[i] = slot_cls[i-1];
                    end
                    slot_tm[pos]  = tm;
                    slot_cls[pos] = cls;
                    held_cnt++;
                    if (cls) cnt_b++;
                    else cnt_a++;
                    if (ins_total != TOTAL_MAX) ins_total++;
                end
            end
            OP_REMOVE: begin
                if (held_cnt > 0) begin
                    if (slot_cls[0]) cnt_b--;
                    else cnt_a--;
                    for (int i = 1; i < held_cnt; i++) begin
                        slot_tm[i-1]  = slot_tm[i];
                        slot_cls[i-1] = slot_cls[i];
                    end
                    held_cnt--;
                end
            end
            OP_CLEAR: ins_total = '0;
            default: ;
        endcase
        s.head   = (held_cnt > 0) ? slot_tm[0] : 16'd0;
        s.empty  = (held_cnt == 0);
        s.occ    = 5'(held_cnt);
        s.held_a = 5'(cnt_a);
        s.held_b = 5'(cnt_b);
        s.total  = ins_total;
        return s;
    endfunction

    function automatic t_dir_row mk_row(t_op op, logic [15:0] tm, logic cls, bit fixed,
                                        logic [15:0] head, logic empty, int occ,
                                        int held_a, int held_b, int total);
        t_dir_row r;
        r.op          = op;
        r.tm          = tm;
        r.cls         = cls;
        r.fixed       = fixed;
        r.lit.head    = head;
        r.lit.empty   = empty;
        r.lit.occ     = 5'(occ);
        r.lit.held_a  = 5'(held_a);
        r.lit.held_b  = 5'(held_b);
        r.lit.total   = 16'(total);
        r.lit.dropped = 1'b0;
        return r;
    endfunction

    // drive one command, hold start until it is taken, return predicted status
    task automatic send_cmd(input t_op op, input logic [15:0] tm, input logic cls,
                            input int gap, output t_queue_status pred);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation   <= op;
        i_expiry_time <= tm;
        i_unit_class  <= cls;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = apply_queue_op(op, tm, cls);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (status_fifo.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] got);
        if (expv !== got) begin
            $error("%s: expected %0d, got %0d", name, expv, got);
            mismatches++;
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_queue_status e;
        if (i_rst_n && o_valid === 1'b1) begin
            if (status_fifo.size() == 0) begin
                $error("unexpected transaction on result channel");
                mismatches++;
            end else begin
                e = status_fifo.pop_front();
                check_field("head_time", e.head, o_head_time);
                check_field("queue_empty", e.empty, o_queue_empty);
                check_field("occupancy", e.occ, o_occupancy);
                check_field("class_a_held", e.held_a, o_class_a_held);
                check_field("class_b_held", e.held_b, o_class_b_held);
                check_field("inserted_total", e.total, o_inserted_total);
                check_field("insert_dropped", e.dropped, o_insert_dropped);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_queue_status pred;
        t_op           op;
        logic [15:0]   tm;
        logic          cls;
        int            gap;
        int            bias;
        int            pick;
        bit            no_idle;

        directed_rows[0]  = mk_row(OP_QUERY,  16'h0000, 1'b0, 1, 16'd0, 1'b1, 0, 0, 0, 0);
        directed_rows[1]  = mk_row(OP_REMOVE, 16'hFFFF, 1'b1, 1, 16'd0, 1'b1, 0, 0, 0, 0);
        directed_rows[2]  = mk_row(OP_CLEAR,  16'hA5A5, 1'b1, 1, 16'd0, 1'b1, 0, 0, 0, 0);
        directed_rows[3]  = mk_row(OP_INSERT, 16'hFFFF, 1'b1, 1, 16'hFFFF, 1'b0, 1, 0, 1, 1);
        directed_rows[4]  = mk_row(OP_INSERT, 16'h0000, 1'b0, 1, 16'd0, 1'b0, 2, 1, 1, 2);
        // tie at the head goes behind the earlier entry
        directed_rows[5]  = mk_row(OP_INSERT, 16'h0000, 1'b1, 1, 16'd0, 1'b0, 3, 1, 2, 3);
        directed_rows[6]  = mk_row(OP_REMOVE, 16'h5A5A, 1'b0, 1, 16'd0, 1'b0, 2, 0, 2, 3);
        directed_rows[7]  = mk_row(OP_CLEAR,  16'hFFFF, 1'b0, 1, 16'd0, 1'b0, 2, 0, 2, 0);
        directed_rows[8]  = mk_row(OP_INSERT, 16'h5555, 1'b0, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[9]  = mk_row(OP_INSERT, 16'hAAAA, 1'b1, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[10] = mk_row(OP_INSERT, 16'h0001, 1'b0, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[11] = mk_row(OP_INSERT, 16'h8000, 1'b1, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[12] = mk_row(OP_INSERT, 16'h7FFF, 1'b0, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[13] = mk_row(OP_INSERT, 16'hFFFE, 1'b1, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[14] = mk_row(OP_INSERT, 16'h00FF, 1'b0, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[15] = mk_row(OP_INSERT, 16'hFF00, 1'b1, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[16] = mk_row(OP_INSERT, 16'h5555, 1'b1, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[17] = mk_row(OP_INSERT, 16'h1234, 1'b0, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[18] = mk_row(OP_INSERT, 16'hFFFF, 1'b0, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[19] = mk_row(OP_INSERT, 16'h0000, 1'b0, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[20] = mk_row(OP_INSERT, 16'h4000, 1'b1, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[21] = mk_row(OP_INSERT, 16'h0002, 1'b0, 0, '0, 0, 0, 0, 0, 0);
        // queue is full here, so this one is dropped
        directed_rows[22] = mk_row(OP_INSERT, 16'h0100, 1'b1, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[23] = mk_row(OP_REMOVE, 16'h0000, 1'b1, 0, '0, 0, 0, 0, 0, 0);
        directed_rows[24] = mk_row(OP_QUERY,  16'hFFFF, 1'b1, 0, '0, 0, 0, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_cmd(directed_rows[k].op, directed_rows[k].tm, directed_rows[k].cls,
                     $urandom_range(0, 16), pred);
            status_fifo.push_back(directed_rows[k].fixed ? directed_rows[k].lit : pred);
        end

        // pause until every outstanding transaction has returned
        wait_all_results();

        bias    = 2;
        no_idle = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 60 == 0) bias = $urandom_range(0, 2);
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (n % 400 == 399) wait_all_results();
            pick = $urandom_range(0, 99);
            case (bias)
                0: op = t_op'((pick < 60) ? OP_INSERT : (pick < 85) ? OP_REMOVE :
                              (pick < 95) ? OP_QUERY : OP_CLEAR);
                1: op = t_op'((pick < 25) ? OP_INSERT : (pick < 85) ? OP_REMOVE :
                              (pick < 95) ? OP_QUERY : OP_CLEAR);
                default: op = t_op'((pick < 42) ? OP_INSERT : (pick < 84) ? OP_REMOVE :
                                    (pick < 94) ? OP_QUERY : OP_CLEAR);
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 5) tm = 16'($urandom);
            else if (pick < 8) tm = 16'($urandom_range(100, 107));
            else if (pick == 8) tm = 16'h0000;
            else tm = 16'hFFFF;
            cls = 1'($urandom_range(0, 1));
            gap = no_idle ? 0 : $urandom_range(0, 16);
            send_cmd(op, tm, cls, gap, pred);
            status_fifo.push_back(pred);
        end

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && status_fifo.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
